>>> sv/quadratic_root_solver_assert.svh
// assertion macros for the quadratic root solver checker
// depends on nothing; included by the checker file
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define QRS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, not disabled
`define QRS_ASSERT_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/qrs_pkg.sv
// shared widths, root kind codes and beat types of the quadratic root solver
// no dependencies
package qrs_pkg;
   localparam int COEF_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int VAL_W    = 48;
   localparam int PROD_W   = 2 * COEF_W;
   localparam int DISC_W   = PROD_W + 3;
   localparam int DMAG_W   = PROD_W + 1;
   localparam int RAD_W    = DMAG_W + 2 * FRAC_W;
   localparam int ROOT_W   = (RAD_W + 1) / 2;
   localparam int NB_W     = COEF_W + FRAC_W + 3;
   localparam int DEN_W    = COEF_W + 2;
   localparam int DENM_W   = COEF_W + 1;
   localparam int NUMS_W   = ROOT_W + 3;
   localparam int NUM_W    = ROOT_W + 1;
   localparam int DIV_W    = NUM_W + DENM_W;

   localparam logic [1:0] KIND_TWO_REAL = 2'd0;
   localparam logic [1:0] KIND_REPEATED = 2'd1;
   localparam logic [1:0] KIND_COMPLEX  = 2'd2;
   localparam logic [1:0] KIND_A_ZERO   = 2'd3;

   // beat moving down the square root row
   typedef struct packed {
      logic                     valid;
      logic [1:0]               kind;
      logic signed [NB_W-1:0]   nb;
      logic signed [DEN_W-1:0]  den;
      logic [RAD_W-1:0]         rem;
      logic [ROOT_W-1:0]        root;
   } sq_beat_type;

   // beat moving down the divider row, two quotients side by side
   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic              neg1;
      logic              neg2;
      logic [DENM_W-1:0] dmag;
      logic [NUM_W-1:0]  rem1;
      logic [NUM_W-1:0]  rem2;
      logic [NUM_W-1:0]  q1;
      logic [NUM_W-1:0]  q2;
   } dv_beat_type;
endpackage

>>> sv/quadratic_root_solver.sv
// top level of the quadratic root solver: discriminant, square root row, divider row
// depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell
//
//  channel | ports                              | handshake
//  --------+------------------------------------+-------------------------
//  request | req_coef_a, req_coef_b, req_coef_c | start high, busy low
//  result  | rsp_root_kind, rsp_first_value,    | rsp_valid, one cycle,
//          | rsp_second_value                   | no back-pressure
//
// one beat accepted every cycle; busy stays low
// pipeline: two multiply/discriminant stages, 33 square root cells,
// a numerator stage, 34 divider cells and the output register
// synchronous reset empties the pipeline; beats in flight are dropped
// the receiver cannot stall, so nothing ever holds the pipeline
module quadratic_root_solver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_c,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_root_kind,
   output logic signed [qrs_pkg::VAL_W-1:0]  rsp_first_value,
   output logic signed [qrs_pkg::VAL_W-1:0]  rsp_second_value
);
   import qrs_pkg::*;

   logic                      v1_ff;
   logic signed [PROD_W-1:0]  bb_ff, ac_ff;
   logic signed [COEF_W-1:0]  a_ff, b_ff;
   logic signed [DISC_W-1:0]  disc;
   logic [DISC_W-1:0]         dabs;
   sq_beat_type               sq_in, sq_ff;
   sq_beat_type               sq_chain [ROOT_W+1];
   sq_beat_type               sq_last;
   logic signed [NUMS_W-1:0]  sroot, nbx, n1, n2;
   logic signed [DEN_W-1:0]   den;
   dv_beat_type               dv_in, dv_ff;
   dv_beat_type               dv_chain [NUM_W+1];
   dv_beat_type               dv_last;
   logic                      out_v_in, out_v_ff;
   logic [1:0]                kind_ff;
   logic signed [VAL_W-1:0]   v1_in, v2_in, val1_ff, val2_ff;

   assign busy = 1'b0;

   // multiply stage
   always_ff @(posedge clock) begin
      bb_ff <= PROD_W'(req_coef_b) * PROD_W'(req_coef_b);
      ac_ff <= PROD_W'(req_coef_a) * PROD_W'(req_coef_c);
      a_ff  <= req_coef_a;
      b_ff  <= req_coef_b;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   // discriminant and classification
   always_comb begin
      disc  = DISC_W'(bb_ff) - (DISC_W'(ac_ff) <<< 2);
      dabs  = disc[DISC_W-1] ? DISC_W'(-disc) : DISC_W'(disc);
      sq_in.valid = v1_ff;
      if (a_ff == '0) begin
         sq_in.kind = KIND_A_ZERO;
      end else if (disc[DISC_W-1]) begin
         sq_in.kind = KIND_COMPLEX;
      end else if (disc == '0) begin
         sq_in.kind = KIND_REPEATED;
      end else begin
         sq_in.kind = KIND_TWO_REAL;
      end
      sq_in.nb   = -(NB_W'(b_ff) <<< FRAC_W);
      sq_in.den  = DEN_W'(a_ff) <<< 1;
      sq_in.rem  = RAD_W'(dabs[DMAG_W-1:0]) << (2 * FRAC_W);
      sq_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff <= '0;
      end else begin
         sq_ff <= sq_in;
      end
   end

   // square root row, top bit first
   assign sq_chain[0] = sq_ff;
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
      qrs_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (sq_chain[k]),
         .beat_out (sq_chain[k+1])
      );
   end
   assign sq_last = sq_chain[ROOT_W];

   // numerators and signs for the two quotient lanes
   always_comb begin
      sroot = $signed({3'b000, sq_last.root});
      nbx   = NUMS_W'(sq_last.nb);
      den   = sq_last.den;
      case (sq_last.kind)
         KIND_TWO_REAL: begin
            n1 = nbx + sroot;
            n2 = nbx - sroot;
         end
         KIND_REPEATED: begin
            n1 = nbx;
            n2 = nbx;
         end
         KIND_COMPLEX: begin
            n1 = nbx;
            n2 = sroot;
         end
         default: begin
            n1 = '0;
            n2 = '0;
         end
      endcase
      dv_in.valid = sq_last.valid;
      dv_in.kind  = sq_last.kind;
      dv_in.neg1  = n1[NUMS_W-1] ^ den[DEN_W-1];
      dv_in.neg2  = n2[NUMS_W-1] ^ den[DEN_W-1];
      dv_in.dmag  = den[DEN_W-1] ? DENM_W'(-den) : DENM_W'(den);
      dv_in.rem1  = n1[NUMS_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
      dv_in.rem2  = n2[NUMS_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
      dv_in.q1    = '0;
      dv_in.q2    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else begin
         dv_ff <= dv_in;
      end
   end

   // divider row, top quotient bit first
   assign dv_chain[0] = dv_ff;
   for (genvar k = 0; k < NUM_W; k++) begin : g_dv
      qrs_div_cell #(.BIT(NUM_W - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (dv_chain[k]),
         .beat_out (dv_chain[k+1])
      );
   end
   assign dv_last = dv_chain[NUM_W];

   // apply signs, zero the values when a is zero
   always_comb begin
      out_v_in = dv_last.valid;
      if (dv_last.kind == KIND_A_ZERO) begin
         v1_in = '0;
         v2_in = '0;
      end else begin
         v1_in = dv_last.neg1 ? -$signed(VAL_W'(dv_last.q1)) : $signed(VAL_W'(dv_last.q1));
         v2_in = dv_last.neg2 ? -$signed(VAL_W'(dv_last.q2)) : $signed(VAL_W'(dv_last.q2));
      end
   end

   // output register
   always_ff @(posedge clock) begin
      kind_ff <= dv_last.kind;
      val1_ff <= v1_in;
      val2_ff <= v2_in;
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_root_kind    = kind_ff;
   assign rsp_first_value  = val1_ff;
   assign rsp_second_value = val2_ff;
endmodule

>>> sv/qrs_sqrt_cell.sv
// one cell of the square root row: settles one root bit per beat
// depends on qrs_pkg
module qrs_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  qrs_pkg::sq_beat_type beat_in,
   output qrs_pkg::sq_beat_type beat_out
);
   import qrs_pkg::*;

   sq_beat_type      beat_ff, beat_in_c;
   logic [RAD_W-1:0] trial;

   // trial = (2r + 2^bit) * 2^bit
   always_comb begin
      trial = (RAD_W'(beat_in.root) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
      beat_in_c = beat_in;
      if (beat_in.rem >= trial) begin
         beat_in_c.rem  = beat_in.rem - trial;
         beat_in_c.root = beat_in.root | (ROOT_W'(1) << BIT);
      end
   end

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in_c;
      end
   end

   assign beat_out = beat_ff;
endmodule

>>> sv/qrs_div_cell.sv
// one cell of the divider row: one quotient bit of both lanes per beat
// depends on qrs_pkg
module qrs_div_cell #(
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  qrs_pkg::dv_beat_type beat_in,
   output qrs_pkg::dv_beat_type beat_out
);
   import qrs_pkg::*;

   dv_beat_type      beat_ff, beat_in_c;
   logic [DIV_W-1:0] shifted;

   // restoring step on both lanes against the shifted divisor
   always_comb begin
      shifted   = DIV_W'(beat_in.dmag) << BIT;
      beat_in_c = beat_in;
      if (DIV_W'(beat_in.rem1) >= shifted) begin
         beat_in_c.rem1 = NUM_W'(DIV_W'(beat_in.rem1) - shifted);
         beat_in_c.q1   = beat_in.q1 | (NUM_W'(1) << BIT);
      end
      if (DIV_W'(beat_in.rem2) >= shifted) begin
         beat_in_c.rem2 = NUM_W'(DIV_W'(beat_in.rem2) - shifted);
         beat_in_c.q2   = beat_in.q2 | (NUM_W'(1) << BIT);
      end
   end

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in_c;
      end
   end

   assign beat_out = beat_ff;
endmodule

>>> sv/qrs_checker.sv
// port checker for the quadratic root solver, bound to the top level
// depends on qrs_pkg and quadratic_root_solver_assert.svh
`include "quadratic_root_solver_assert.svh"

module qrs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic signed [qrs_pkg::COEF_W-1:0] req_coef_a,
   input logic                              rsp_valid,
   input logic [1:0]                        rsp_root_kind,
   input logic signed [qrs_pkg::VAL_W-1:0]  rsp_first_value,
   input logic signed [qrs_pkg::VAL_W-1:0]  rsp_second_value
);
   import qrs_pkg::*;

   localparam int LATENCY = 71;

   logic accept, accept_a_zero, out_a_zero, out_repeat, zero_vals;

   // handshake and result conditions
   assign accept        = start && !busy;
   assign accept_a_zero = accept && req_coef_a == '0;
   assign out_a_zero    = rsp_valid && rsp_root_kind == KIND_A_ZERO;
   assign out_repeat    = rsp_valid && rsp_root_kind == KIND_REPEATED;
   assign zero_vals     = rsp_first_value == '0 && rsp_second_value == '0;

   // every accepted beat comes out after the fixed latency
   `QRS_ASSERT_IMP(a_latency, clock, reset, accept, ##LATENCY rsp_valid)
   // a beat with a zero leading coefficient reports kind a-zero
   `QRS_ASSERT_IMP(a_zero_kind, clock, reset, accept_a_zero, ##LATENCY out_a_zero)
   // a-zero and repeated results carry consistent values
   `QRS_ASSERT_IMP(a_zero_vals, clock, reset, out_a_zero, zero_vals)
   `QRS_ASSERT_IMP(a_repeat, clock, reset, out_repeat, rsp_first_value == rsp_second_value)
   // reset empties the pipeline
   `QRS_ASSERT_NXT(a_reset, clock, reset, !rsp_valid)
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
